[rtl/ssms_pkg.sv]
`default_nettype none

package ssms_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned SPAN_W  = 17;

  localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(65536);

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned MAX_DAYS_DEF    = 65536;

endpackage

`default_nettype wire

[rtl/ssms_if.sv]
`default_nettype none

interface ssms_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssms_pkg::PRICE_W-1:0] price;
  logic                         start_of_series;

  modport source (output valid, output price, output start_of_series, input ready);
  modport sink   (input valid, input price, input start_of_series, output ready);
endinterface

interface ssms_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssms_pkg::SPAN_W-1:0] span;
  logic                        overflow;

  modport source (output valid, output span, output overflow, input ready);
  modport sink   (input valid, input span, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/ssms_stack_ram.sv]
`default_nettype none

module ssms_stack_ram #(
  parameter int unsigned DEPTH = ssms_pkg::STACK_DEPTH_DEF,
  parameter int unsigned WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/stock_span_monotonic_stack_core.sv]
// an accepted quote goes straight from idle to finish on an empty stack or a passed day
// limit, otherwise through the compare state at one stack compare per cycle (pops, plus
// one if an entry remains), then to finish, which holds until the output register is free;
// compares use the single stack ram read port, and new quotes are accepted only in idle
// reset: stack empty and day count zero at once, no clearing pass; ram contents undefined
`default_nettype none

module stock_span_monotonic_stack_core #(
  parameter int unsigned STACK_DEPTH = ssms_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_DAYS    = ssms_pkg::MAX_DAYS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssms_in_if.sink   in_i,
  ssms_out_if.source out_o
);

  localparam int unsigned AW     = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DAY_W  = $clog2(MAX_DAYS + 1);
  localparam int unsigned SDAY_W = $clog2(MAX_DAYS);
  localparam int unsigned PW     = ssms_pkg::PRICE_W;
  localparam int unsigned SW     = ssms_pkg::SPAN_W;
  localparam int unsigned SFW    = (DAY_W + 1 > SW + 1) ? DAY_W + 1 : SW + 1;
  localparam int unsigned MW     = PW + SDAY_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [DAY_W-1:0] DAY_LIM  = DAY_W'(MAX_DAYS);
  localparam logic [SFW-1:0]   SPAN_SAT = SFW'(ssms_pkg::SPAN_MAX);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DAY_W-1:0]  day_q, day_d;
  logic [PW-1:0]     price_q, price_d;
  logic              lim_q, lim_d;
  logic              top_vld_q, top_vld_d;
  logic [SDAY_W-1:0] top_day_q, top_day_d;
  logic              out_vld_q, out_vld_d;
  logic [SW-1:0]     span_q, span_d;
  logic              ovf_q, ovf_d;

  logic              in_acc;
  logic              out_free;
  logic [CNT_W-1:0]  cnt_eff;
  logic [DAY_W-1:0]  day_eff;
  logic [CNT_W-1:0]  rd_ptr;
  logic              ram_we;
  logic [MW-1:0]     ram_rdata;
  logic [PW-1:0]     rd_price;
  logic [SDAY_W-1:0] rd_day;
  logic [SFW-1:0]    span_full;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign cnt_eff  = in_i.start_of_series ? '0 : cnt_q;
  assign day_eff  = in_i.start_of_series ? '0 : day_q;
  assign rd_price = ram_rdata[MW-1:SDAY_W];
  assign rd_day   = ram_rdata[SDAY_W-1:0];

  assign span_full = top_vld_q ? (SFW'(day_q) - SFW'(top_day_q)) : (SFW'(day_q) + SFW'(1));

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_vld_q;
  assign out_o.span     = span_q;
  assign out_o.overflow = ovf_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    day_d     = day_q;
    price_d   = price_q;
    lim_d     = lim_q;
    top_vld_d = top_vld_q;
    top_day_d = top_day_q;
    out_vld_d = out_vld_q && !out_o.ready;
    span_d    = span_q;
    ovf_d     = ovf_q;
    rd_ptr    = cnt_q - CNT_W'(2);
    ram_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_ptr = cnt_eff - CNT_W'(1);
        if (in_acc) begin
          cnt_d     = cnt_eff;
          day_d     = day_eff;
          price_d   = in_i.price;
          lim_d     = (day_eff >= DAY_LIM);
          top_vld_d = 1'b0;
          if ((day_eff >= DAY_LIM) || (cnt_eff == '0)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (rd_price <= price_q) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            top_vld_d = 1'b0;
            state_d   = ST_FIN;
          end
        end else begin
          top_vld_d = 1'b1;
          top_day_d = rd_day;
          state_d   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if (lim_q) begin
            span_d = ssms_pkg::SPAN_MAX;
            ovf_d  = 1'b1;
          end else begin
            day_d = day_q + DAY_W'(1);
            if (span_full > SPAN_SAT) begin
              span_d = ssms_pkg::SPAN_MAX;
              ovf_d  = 1'b1;
            end else begin
              span_d = span_full[SW-1:0];
              ovf_d  = 1'b0;
            end
            if (cnt_q == CNT_FULL) begin
              span_d = ssms_pkg::SPAN_MAX;
              ovf_d  = 1'b1;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      day_q     <= '0;
      lim_q     <= 1'b0;
      top_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      day_q     <= day_d;
      lim_q     <= lim_d;
      top_vld_q <= top_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q   <= price_d;
    top_day_q <= top_day_d;
    span_q    <= span_d;
    ovf_q     <= ovf_d;
  end

  ssms_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(MW)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({price_q, day_q[SDAY_W-1:0]}),
    .raddr_i(rd_ptr[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // stack compares only run on a non-empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (cnt_q != '0))
    else $error("compare on empty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_FULL) && (day_q <= DAY_LIM))
    else $error("stack count or day count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("accepted transaction not started");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!lim_q && (cnt_q < CNT_FULL)))
    else $error("push on full stack or past day limit");

endmodule

`default_nettype wire

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRICE_W        = ssms_pkg::PRICE_W;
  localparam int unsigned SPAN_W         = ssms_pkg::SPAN_W;
  localparam logic [SPAN_W-1:0] SPAN_MAX = ssms_pkg::SPAN_MAX;
  localparam int unsigned DEPTH          = ssms_pkg::STACK_DEPTH_DEF;
  localparam int unsigned DAY_LIMIT      = ssms_pkg::MAX_DAYS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned RANDOM_QUOTES  = 900;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              overflow;
  } span_res_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               new_series;
    logic               fixed;
    logic [SPAN_W-1:0]  span;
    logic               overflow;
  } quote_row_t;

  typedef enum int unsigned {
    SHAPE_NOISE, SHAPE_FLAT, SHAPE_FALL, SHAPE_RISE, SHAPE_EDGE, SHAPE_WALK
  } price_shape_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ssms_in_if  quote_if ();
  ssms_out_if span_if ();

  stock_span_monotonic_stack_core #(
    .STACK_DEPTH(DEPTH),
    .MAX_DAYS   (DAY_LIMIT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (quote_if),
    .out_o (span_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [PRICE_W-1:0] ledger_price [DEPTH];
  int unsigned        ledger_day   [DEPTH];
  int unsigned        ledger_cnt;
  int unsigned        day_cnt;
  int unsigned        peak_depth;

  span_res_t   span_q [$];
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned fail_cnt;
  int unsigned quote_cnt;
  int unsigned span_cnt;
  int unsigned ovf_cnt;
  int unsigned idle_cycles;

  quote_row_t quote_table [23] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 17'd1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0005, 1'b1, 1'b1, 17'd1, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0004, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h0000_0008, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 17'd1, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 17'd1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, 17'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 17'd1, 1'b0}
  };

  function automatic span_res_t predict_span(input logic [PRICE_W-1:0] price,
                                             input logic new_series);
    span_res_t   res;
    int unsigned today;
    int unsigned days;
    res.overflow = 1'b0;
    if (new_series) begin
      ledger_cnt = 0;
      day_cnt    = 0;
    end
    // past the day limit the stack is frozen
    if (day_cnt >= DAY_LIMIT) begin
      day_cnt      = DAY_LIMIT;
      res.span     = SPAN_MAX;
      res.overflow = 1'b1;
      return res;
    end
    today = day_cnt;
    while (ledger_cnt > 0 && ledger_price[ledger_cnt-1] <= price) begin
      ledger_cnt--;
    end
    days = (ledger_cnt == 0) ? today + 1 : today - ledger_day[ledger_cnt-1];
    if (days > SPAN_MAX) begin
      days         = SPAN_MAX;
      res.overflow = 1'b1;
    end
    if (ledger_cnt < DEPTH) begin
      ledger_price[ledger_cnt] = price;
      ledger_day[ledger_cnt]   = today;
      ledger_cnt++;
      if (ledger_cnt > peak_depth) begin
        peak_depth = ledger_cnt;
      end
    end else begin
      days         = SPAN_MAX;
      res.overflow = 1'b1;
    end
    day_cnt  = today + 1;
    res.span = SPAN_W'(days);
    return res;
  endfunction

  task automatic send_quote(input logic [PRICE_W-1:0] price, input logic new_series,
                            input logic fixed, input logic [SPAN_W-1:0] span,
                            input logic overflow);
    span_res_t due;
    while ($urandom_range(99) < snd_idle_pct) begin
      quote_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    quote_if.valid           <= 1'b1;
    quote_if.price           <= price;
    quote_if.start_of_series <= new_series;
    @(posedge clk_i);
    while (!quote_if.ready) begin
      @(posedge clk_i);
    end
    due = predict_span(price, new_series);
    if (fixed) begin
      due.span     = span;
      due.overflow = overflow;
    end
    if (due.overflow) begin
      ovf_cnt++;
    end
    span_q.insert(span_q.size(), due);
    quote_cnt++;
  endtask

  // hold the sender until every outstanding span is back
  task automatic wait_drained();
    quote_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (span_q.size() != 0);
  endtask

  task automatic run_random(input int unsigned goal);
    int unsigned        sent;
    int unsigned        len;
    price_shape_e       shape;
    logic [PRICE_W-1:0] level;
    logic [PRICE_W-1:0] price;
    logic               new_series;
    sent = 0;
    while (sent < goal) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
      shape = price_shape_e'($urandom_range(5));
      level = $urandom;
      for (int unsigned k = 0; k < len && sent < goal; k++) begin
        case (shape)
          SHAPE_NOISE: begin
            price = $urandom;
          end
          SHAPE_FLAT: begin
            price = level + $urandom_range(2);
          end
          SHAPE_FALL: begin
            level = ($urandom_range(15) == 0) ? $urandom : level - $urandom_range(1000);
            price = level;
          end
          SHAPE_RISE: begin
            level = level + $urandom_range(1000);
            price = level;
          end
          SHAPE_EDGE: begin
            case ($urandom_range(3))
              0:       price = '0;
              1:       price = '1;
              2:       price = 32'h8000_0000;
              default: price = 32'h7FFF_FFFF;
            endcase
          end
          default: begin
            level = level + $urandom_range(16) - 8;
            price = level;
          end
        endcase
        // mostly clean series, some continue the old one or restart mid-way
        new_series = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(99) == 0);
        send_quote(price, new_series, 1'b0, '0, 1'b0);
        sent++;
      end
    end
  endtask

  // one series that fills the stack, pops part of it, fills it again and clears it
  task automatic run_long_series();
    logic [PRICE_W-1:0] price;
    for (int unsigned d = 0; d < DEPTH + 8; d++) begin
      if (d == DEPTH + 2) begin
        price = ~(DEPTH - 4);
      end else if (d == DEPTH + 6) begin
        price = '1;
      end else begin
        price = ~d;
      end
      send_quote(price, d == 0, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    rst_ni                   = 1'b0;
    quote_if.valid           <= 1'b0;
    quote_if.price           <= '0;
    quote_if.start_of_series <= 1'b0;
    snd_idle_pct = 22;
    rcv_idle_pct = 63;
    fail_cnt     = 0;
    quote_cnt    = 0;
    span_cnt     = 0;
    ovf_cnt      = 0;
    ledger_cnt   = 0;
    day_cnt      = 0;
    peak_depth   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (quote_table[i]) begin
      send_quote(quote_table[i].price, quote_table[i].new_series, quote_table[i].fixed,
                 quote_table[i].span, quote_table[i].overflow);
    end
    run_random(RANDOM_QUOTES / 3);
    wait_drained();

    snd_idle_pct = 63;
    rcv_idle_pct = 22;
    run_random(RANDOM_QUOTES / 3);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_long_series();
    run_random(RANDOM_QUOTES - 2 * (RANDOM_QUOTES / 3));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d price quotes sent, %0d spans checked, %0d of them flagged overflow",
             quote_cnt, span_cnt, ovf_cnt);
    $display("stack filled to %0d entries, partly popped, refilled and cleared in one go",
             peak_depth);
    if (fail_cnt == 0) begin
      $display("stock_span_monotonic_stack_core regression: pass");
    end else begin
      $display("stock_span_monotonic_stack_core regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin : span_check
    span_res_t due;
    if (rst_ni && span_if.valid && span_if.ready) begin
      span_cnt++;
      if (span_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("%0t: span %0d overflow %0b with no transaction outstanding",
                   $realtime, span_if.span, span_if.overflow);
        end
      end else begin
        due = span_q.pop_front();
        if (span_if.span !== due.span) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: span expected %0d, got %0d", $realtime, due.span, span_if.span);
          end
        end
        if (span_if.overflow !== due.overflow) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: overflow expected %0b, got %0b",
                     $realtime, due.overflow, span_if.overflow);
          end
        end
      end
    end
    span_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (quote_if.valid && quote_if.ready) || (span_if.valid && span_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("stock_span_monotonic_stack_core regression: fail");
      $finish;
    end
  end

endmodule
